// File: rtl/ukt_pkg.sv
// Shared types and codes for the unique-key table with compaction.
// No dependencies; imported by ukt_cell and unique_key_table_compacting.
package ukt_pkg;

  localparam int KEY_BITS    = 64;
  localparam int IN_DATA_W   = 32;
  localparam int IDX_BITS    = 5;
  localparam int STATUS_BITS = 3;
  localparam int COUNT_OUT_W = 6;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } ukt_op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK     = 3'd0,
    ST_DUP    = 3'd1,
    ST_FULL   = 3'd2,
    ST_NOKEY  = 3'd3,
    ST_RANGE  = 3'd4
  } ukt_status_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp;    // compare phase: register key match and read select
    logic wr;     // append at the cell whose position equals the count
    logic shift;  // close the gap: cells at or above the match take their upper neighbour
  } ukt_ctrl_t;

endpackage

// File: rtl/unique_key_table_compacting.sv
// Unique-key table with compaction: a row of ukt_cell instances and the sequencer.
// Depends on ukt_pkg and ukt_cell.
// An accepted transaction passes the compare state, then the execute state; the result strobe is registered.
// A new transaction can be accepted in the execute state of the last one (compare in all cells, then write or shift).
// busy is high only during the compare cycle; the result strobe lasts one cycle.
// Reset (rst_n low, synchronous) empties the table and clears the sequencer.
module unique_key_table_compacting #(
  parameter int CAPACITY  = 32,
  parameter int DATA_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_op,
  input  logic [ukt_pkg::KEY_BITS-1:0]    in_entry_key,
  input  logic [ukt_pkg::IN_DATA_W-1:0]   in_entry_data,
  input  logic [ukt_pkg::IDX_BITS-1:0]    in_read_index,
  output logic                            out_strobe,
  output logic [ukt_pkg::STATUS_BITS-1:0] out_status,
  output logic [ukt_pkg::COUNT_OUT_W-1:0] out_entry_count,
  output logic [ukt_pkg::KEY_BITS-1:0]    out_found_key,
  output logic [ukt_pkg::IN_DATA_W-1:0]   out_found_data
);
  import ukt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_t;

  state_t               state_r, state_nxt;
  ukt_op_t              op_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [DATA_BITS-1:0] data_r;
  logic [IDX_BITS-1:0]  idx_r;
  logic [CNT_W-1:0]     count_r, count_nxt;

  logic                   strobe_r, strobe_nxt;
  logic [STATUS_BITS-1:0] status_r, status_nxt;
  logic [KEY_BITS-1:0]    fkey_r, fkey_nxt;
  logic [IN_DATA_W-1:0]   fdata_r, fdata_nxt;

  ukt_ctrl_t ctrl;
  logic      accept;

  logic [KEY_BITS-1:0]  cell_key  [CAPACITY];
  logic [DATA_BITS-1:0] cell_data [CAPACITY];
  logic [KEY_BITS-1:0]  up_key    [CAPACITY];
  logic [DATA_BITS-1:0] up_data   [CAPACITY];
  logic [CAPACITY:0]    seen;
  logic [CAPACITY-1:0]  hit_vec;
  logic [CAPACITY-1:0]  sel_vec;
  logic                 any_hit;
  logic                 any_sel;
  logic                 full;
  logic [KEY_BITS-1:0]  rd_key;
  logic [DATA_BITS-1:0] rd_data;

  assign busy   = (state_r == S_CMP);
  assign accept = start && !busy;

  assign seen[0] = 1'b0;
  assign any_hit = seen[CAPACITY];
  assign any_sel = |sel_vec;
  assign full    = (count_r >= CNT_W'(CAPACITY));

  always_comb begin
    ctrl       = '0;
    ctrl.cmp   = (state_r == S_CMP);
    ctrl.wr    = (state_r == S_EXEC) && (op_r == OP_ADD) && !any_hit && !full;
    ctrl.shift = (state_r == S_EXEC) && (op_r == OP_REMOVE) && any_hit;
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g + 1 < CAPACITY) begin : g_up
        assign up_key[g]  = cell_key[g+1];
        assign up_data[g] = cell_data[g+1];
      end else begin : g_top
        assign up_key[g]  = '0;
        assign up_data[g] = '0;
      end

      ukt_cell #(
        .POS       (g),
        .CNT_W     (CNT_W),
        .DATA_BITS (DATA_BITS)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .count    (count_r),
        .op_key   (key_r),
        .op_data  (data_r),
        .op_idx   (idx_r),
        .up_key   (up_key[g]),
        .up_data  (up_data[g]),
        .seen_in  (seen[g]),
        .seen_out (seen[g+1]),
        .hit      (hit_vec[g]),
        .rd_sel   (sel_vec[g]),
        .key      (cell_key[g]),
        .data     (cell_data[g])
      );
    end
  endgenerate

  // At most one cell is selected, so an OR of the gated entries picks it.
  always_comb begin
    rd_key  = '0;
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_key  = rd_key  | (cell_key[i]  & {KEY_BITS{sel_vec[i]}});
      rd_data = rd_data | (cell_data[i] & {DATA_BITS{sel_vec[i]}});
    end
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    fkey_nxt   = fkey_r;
    fdata_nxt  = fdata_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt  = accept ? S_CMP : S_IDLE;
        strobe_nxt = 1'b1;
        status_nxt = ST_OK;
        fkey_nxt   = '0;
        fdata_nxt  = '0;
        unique case (op_r)
          OP_ADD: begin
            if (any_hit)   status_nxt = ST_DUP;
            else if (full) status_nxt = ST_FULL;
            else           count_nxt  = count_r + CNT_W'(1);
          end
          OP_REMOVE: begin
            if (any_hit) count_nxt  = count_r - CNT_W'(1);
            else         status_nxt = ST_NOKEY;
          end
          OP_READ: begin
            if (any_sel) begin
              fkey_nxt  = rd_key;
              fdata_nxt = IN_DATA_W'(rd_data);
            end else begin
              status_nxt = ST_RANGE;
            end
          end
          OP_CLEAR: begin
            count_nxt = '0;
          end
          default: ;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
      status_r <= ST_OK;
      fkey_r   <= '0;
      fdata_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
      status_r <= status_nxt;
      fkey_r   <= fkey_nxt;
      fdata_r  <= fdata_nxt;
    end
  end

  // Hold the transaction's fields for the compare and execute cycles.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= ukt_op_t'(in_op);
      key_r  <= in_entry_key;
      data_r <= DATA_BITS'(in_entry_data);
      idx_r  <= in_read_index;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_entry_count = COUNT_OUT_W'(count_r);
  assign out_found_key   = fkey_r;
  assign out_found_data  = fdata_r;

  // Keys are unique among live entries, so a lookup matches at most one cell.
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> $onehot0(hit_vec))
    else $error("more than one cell matched the key");

  a_single_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> $onehot0(sel_vec))
    else $error("more than one cell selected for read");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == S_EXEC))
    else $error("result strobe without an execute cycle");

endmodule

// File: rtl/ukt_cell.sv
// One table position: key, payload, match flag and read select.
// Depends on ukt_pkg; instantiated in a row by unique_key_table_compacting.
module ukt_cell #(
  parameter int POS       = 0,
  parameter int CNT_W     = 6,
  parameter int DATA_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ukt_pkg::ukt_ctrl_t           ctrl,
  input  logic [CNT_W-1:0]             count,
  input  logic [ukt_pkg::KEY_BITS-1:0] op_key,
  input  logic [DATA_BITS-1:0]         op_data,
  input  logic [ukt_pkg::IDX_BITS-1:0] op_idx,
  input  logic [ukt_pkg::KEY_BITS-1:0] up_key,
  input  logic [DATA_BITS-1:0]         up_data,
  input  logic                         seen_in,
  output logic                         seen_out,
  output logic                         hit,
  output logic                         rd_sel,
  output logic [ukt_pkg::KEY_BITS-1:0] key,
  output logic [DATA_BITS-1:0]         data
);
  import ukt_pkg::*;

  localparam bit READABLE = (POS < (1 << IDX_BITS));

  logic [KEY_BITS-1:0]  key_r;
  logic [DATA_BITS-1:0] data_r;
  logic                 hit_r;
  logic                 rd_sel_r;
  logic                 live;
  logic                 at_tail;

  assign live     = (CNT_W'(POS) < count);
  assign at_tail  = (CNT_W'(POS) == count);
  assign seen_out = seen_in | hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r    <= 1'b0;
      rd_sel_r <= 1'b0;
    end else if (ctrl.cmp) begin
      hit_r    <= live && (key_r == op_key);
      rd_sel_r <= READABLE && live && (op_idx == IDX_BITS'(POS));
    end
  end

  // Payload holds no reset; entries beyond the count are never read.
  always_ff @(posedge clk) begin
    if (ctrl.wr && at_tail) begin
      key_r  <= op_key;
      data_r <= op_data;
    end else if (ctrl.shift && seen_out) begin
      key_r  <= up_key;
      data_r <= up_data;
    end
  end

  assign hit    = hit_r;
  assign rd_sel = rd_sel_r;
  assign key    = key_r;
  assign data   = data_r;

endmodule
